/* rtl/wesch_pkg.sv */
// shared types, codes and constants of the weekly event scheduler
package wesch_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int ENTRIES_MAX = 64;

  localparam logic [5:0] HALF_MINUTE = 6'd30;

  localparam logic [1:0] OP_CONFIG = 2'd0;
  localparam logic [1:0] OP_ATTACH = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_OFF      = 2'd0;
  localparam logic [1:0] ST_ARMED    = 2'd1;
  localparam logic [1:0] ST_BUSY     = 2'd2;
  localparam logic [1:0] ST_INACTIVE = 2'd3;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic       start_en;
    logic [4:0] start_hour;
    logic [5:0] start_min;
    logic       end_en;
    logic [4:0] end_hour;
    logic [5:0] end_min;
    logic [7:0] mask;
    logic       has_start;
    logic       has_end;
  } entry_t;

  localparam entry_t ENTRY_RST = '{
    status:     ST_OFF,
    start_en:   1'b1,
    start_hour: 5'd0,
    start_min:  6'd0,
    end_en:     1'b1,
    end_hour:   5'd0,
    end_min:    6'd0,
    mask:       8'd0,
    has_start:  1'b0,
    has_end:    1'b0
  };

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] weekday;
    logic [5:0] second;
  } tick_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] act;
  } eval_res_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] entry_index;
    logic [1:0] status_value;
    logic       start_on;
    logic [4:0] hour_a;
    logic [5:0] minute_a;
    logic       end_on;
    logic [4:0] hour_b;
    logic [5:0] minute_b;
    logic [2:0] bit_index;
    logic       bit_value;
    logic [5:0] second_now;
  } in_item_t;

endpackage

/* rtl/wesch_in_if.sv */
// request channel of the weekly event scheduler
interface wesch_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] entry_index;
  logic [1:0] status_value;
  logic       start_on;
  logic [4:0] hour_a;
  logic [5:0] minute_a;
  logic       end_on;
  logic [4:0] hour_b;
  logic [5:0] minute_b;
  logic [2:0] bit_index;
  logic       bit_value;
  logic [5:0] second_now;

  modport source (
    output valid, opcode, entry_index, status_value, start_on, hour_a, minute_a,
           end_on, hour_b, minute_b, bit_index, bit_value, second_now,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, status_value, start_on, hour_a, minute_a,
           end_on, hour_b, minute_b, bit_index, bit_value, second_now,
    output ready
  );
endinterface

/* rtl/wesch_out_if.sv */
// result channel of the weekly event scheduler
interface wesch_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] entry_out;
  logic [1:0] action_fired;
  logic [1:0] status_out;
  logic       last;

  modport source (
    output valid, entry_out, action_fired, status_out, last,
    input  ready
  );
  modport sink (
    input  valid, entry_out, action_fired, status_out, last,
    output ready
  );
endinterface

/* rtl/wesch_eval.sv */
// per-entry tick evaluation, shared by all entries of a tick
module wesch_eval import wesch_pkg::*; (
  input  entry_t    cur,
  input  tick_t     tick,
  output eval_res_t res
);

  logic       at_start;
  logic       at_end;
  logic       day_ok;
  logic [1:0] after_end;

  assign at_start  = (cur.start_hour == tick.hour) && (cur.start_min == tick.minute);
  assign at_end    = (cur.end_hour == tick.hour) && (cur.end_min == tick.minute);
  assign day_ok    = cur.mask[tick.weekday] || (cur.mask == 8'd0);
  assign after_end = (cur.mask != 8'd0) ? ST_ARMED : ST_OFF;

  always_comb begin
    res.status = cur.status;
    res.act    = ACT_NONE;
    if (cur.status == ST_ARMED && day_ok && at_start && tick.second < HALF_MINUTE) begin
      if (cur.start_en && cur.has_start) begin
        res.act = ACT_START;
      end
      res.status = ST_BUSY;
    end
    // end check sees the status left by the start check
    if (res.status == ST_BUSY) begin
      if (cur.has_end) begin
        if (at_end && tick.second > HALF_MINUTE) begin
          if (cur.end_en) begin
            res.act = ACT_END;
          end
          res.status = after_end;
        end
      end else if (at_start && tick.second > HALF_MINUTE) begin
        res.status = after_end;
      end
    end
  end

endmodule

/* rtl/weekly_event_scheduler_core.sv */
// Weekly event scheduler: a table of ENTRIES events in a one-port-write,
// one-port-read memory, updated by configure and attach requests and walked
// by time ticks. Configure, attach and unused opcodes give no result. A tick
// reads entry 0 in its accept cycle, then evaluates one entry per cycle
// through a single shared evaluation unit while the next entry is read;
// the walk pauses while the output register holds an untaken result. One
// result per entry, in index order, with last set on the final one. Entries
// never written read as their reset values through per-entry valid bits, so
// no clearing pass follows reset.
module weekly_event_scheduler_core import wesch_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  wesch_in_if.sink    in_ch,
  wesch_out_if.source out_ch
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;

  logic [1:0]         state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [ENTRIES-1:0] vld_r;
  entry_t             rd_data_r;
  logic               rd_vld_r;
  entry_t             mem [ENTRIES];

  logic       out_valid_r, out_valid_nxt;
  logic [5:0] entry_out_r, entry_out_nxt;
  logic [1:0] act_r, act_nxt;
  logic [1:0] status_out_r, status_out_nxt;
  logic       last_r, last_nxt;

  logic             in_acc;
  logic             out_free;
  logic             adv;
  logic             is_last;
  logic             addr_ok;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  entry_t           cur;
  tick_t            tick;
  eval_res_t        res;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = (state_r == S_TICK) && out_free;
  assign is_last     = (k_r == LAST_IDX);
  assign addr_ok     = ({1'b0, item_r.entry_index} < 9'(ENTRIES));
  assign cur         = rd_vld_r ? rd_data_r : ENTRY_RST;

  assign tick.hour    = item_r.hour_a;
  assign tick.minute  = item_r.minute_a;
  assign tick.weekday = item_r.bit_index;
  assign tick.second  = item_r.second_now;

  wesch_eval u_eval (
    .cur  (cur),
    .tick (tick),
    .res  (res)
  );

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    k_nxt     = k_r;
    rd_en     = 1'b0;
    rd_addr   = k_r;
    we        = 1'b0;
    wr_addr   = item_r.entry_index[IDX_W-1:0];
    wr_data   = cur;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt.opcode       = in_ch.opcode;
          item_nxt.entry_index  = in_ch.entry_index;
          item_nxt.status_value = in_ch.status_value;
          item_nxt.start_on     = in_ch.start_on;
          item_nxt.hour_a       = in_ch.hour_a;
          item_nxt.minute_a     = in_ch.minute_a;
          item_nxt.end_on       = in_ch.end_on;
          item_nxt.hour_b       = in_ch.hour_b;
          item_nxt.minute_b     = in_ch.minute_b;
          item_nxt.bit_index    = in_ch.bit_index;
          item_nxt.bit_value    = in_ch.bit_value;
          item_nxt.second_now   = in_ch.second_now;
          rd_en = 1'b1;
          k_nxt = '0;
          if (in_ch.opcode == OP_TICK) begin
            rd_addr   = '0;
            state_nxt = S_TICK;
          end else begin
            rd_addr   = in_ch.entry_index[IDX_W-1:0];
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        state_nxt = S_IDLE;
        if (addr_ok && item_r.opcode == OP_CONFIG) begin
          we                 = 1'b1;
          wr_data.status     = item_r.status_value;
          wr_data.start_en   = item_r.start_on;
          wr_data.start_hour = item_r.hour_a;
          wr_data.start_min  = item_r.minute_a;
          wr_data.end_en     = item_r.end_on;
          wr_data.end_hour   = item_r.hour_b;
          wr_data.end_min    = item_r.minute_b;
          if (item_r.bit_value) begin
            wr_data.mask = cur.mask | (8'd1 << item_r.bit_index);
          end else begin
            wr_data.mask = cur.mask & ~(8'd1 << item_r.bit_index);
          end
        end else if (addr_ok && item_r.opcode == OP_ATTACH) begin
          we                = 1'b1;
          wr_data.has_start = item_r.start_on;
          wr_data.has_end   = item_r.end_on;
        end
      end
      S_TICK: begin
        if (adv) begin
          // write back entry k and, unless it is the last, read entry k + 1
          we             = 1'b1;
          wr_addr        = k_r;
          wr_data.status = res.status;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = k_r + 1'b1;
            k_nxt   = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    entry_out_nxt  = entry_out_r;
    act_nxt        = act_r;
    status_out_nxt = status_out_r;
    last_nxt       = last_r;
    if (adv) begin
      out_valid_nxt  = 1'b1;
      entry_out_nxt  = 6'(k_r);
      act_nxt        = res.act;
      status_out_nxt = res.status;
      last_nxt       = is_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    entry_out_r  <= entry_out_nxt;
    act_r        <= act_nxt;
    status_out_r <= status_out_nxt;
    last_r       <= last_nxt;
  end

  // entry table
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.entry_out    = entry_out_r;
  assign out_ch.action_fired = act_r;
  assign out_ch.status_out   = status_out_r;
  assign out_ch.last         = last_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready
  ) else $error("request taken while previous one still in work");

  a_last_ends_tick: assert property (
    @(posedge clk) disable iff (!rst_n)
    (adv && is_last) |=> (state_r == S_IDLE) && out_ch.valid && out_ch.last
  ) else $error("tick did not finish on its final entry");

  a_inactive_kept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (adv && cur.status == ST_INACTIVE) |-> (res.status == ST_INACTIVE && res.act == ACT_NONE)
  ) else $error("inactive entry changed during a tick");

  a_index_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK) |-> ({1'b0, k_r} <= (IDX_W + 1)'(ENTRIES - 1))
  ) else $error("tick walk index beyond the table");
`endif

endmodule

/* bench/weekly_event_scheduler_core_tb.sv */
// testbench of the weekly event scheduler core: directed and random requests, self-checking
`timescale 1ns / 100ps

module weekly_event_scheduler_core_tb;
  import wesch_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         NUM_ENTRIES = ENTRIES_DEF;
  localparam int         TAIL_CYCLES = NUM_ENTRIES + 6;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         MAX_SHOWN   = 10;

  typedef struct packed {
    logic [5:0] entry;
    logic [1:0] act;
    logic [1:0] status;
    logic       last;
  } entry_report_t;

  logic clk;
  logic rst_n;

  wesch_in_if  in_ch();
  wesch_out_if out_ch();

  weekly_event_scheduler_core #(
    .ENTRIES(NUM_ENTRIES)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  entry_t        sched_table [NUM_ENTRIES];
  entry_report_t pending_reports [$];

  int errors       = 0;
  int cycle_count  = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold      = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // scheduler table model: updates the entries and queues the reports of a tick
  function automatic void apply_request(in_item_t req);
    entry_report_t rep;
    logic          at_start;
    logic          day_ok;
    logic [1:0]    act;
    int            k;
    if (req.opcode == OP_CONFIG) begin
      if (req.entry_index < NUM_ENTRIES) begin
        sched_table[req.entry_index].status     = req.status_value;
        sched_table[req.entry_index].start_en   = req.start_on;
        sched_table[req.entry_index].start_hour = req.hour_a;
        sched_table[req.entry_index].start_min  = req.minute_a;
        sched_table[req.entry_index].end_en     = req.end_on;
        sched_table[req.entry_index].end_hour   = req.hour_b;
        sched_table[req.entry_index].end_min    = req.minute_b;
        sched_table[req.entry_index].mask[req.bit_index] = req.bit_value;
      end
    end else if (req.opcode == OP_ATTACH) begin
      if (req.entry_index < NUM_ENTRIES) begin
        sched_table[req.entry_index].has_start = req.start_on;
        sched_table[req.entry_index].has_end   = req.end_on;
      end
    end else if (req.opcode == OP_TICK) begin
      for (k = 0; k < NUM_ENTRIES; k++) begin
        act = ACT_NONE;
        at_start = (sched_table[k].start_hour == req.hour_a) &&
                   (sched_table[k].start_min == req.minute_a);
        if (sched_table[k].status == ST_ARMED) begin
          day_ok = sched_table[k].mask[req.bit_index] || (sched_table[k].mask == 8'd0);
          if (day_ok && at_start && req.second_now < HALF_MINUTE) begin
            if (sched_table[k].start_en && sched_table[k].has_start)
              act = ACT_START;
            sched_table[k].status = ST_BUSY;
          end
        end
        if (sched_table[k].status == ST_BUSY) begin
          if (sched_table[k].has_end) begin
            if (sched_table[k].end_hour == req.hour_a && sched_table[k].end_min == req.minute_a &&
                req.second_now > HALF_MINUTE) begin
              if (sched_table[k].end_en)
                act = ACT_END;
              sched_table[k].status = (sched_table[k].mask != 8'd0) ? ST_ARMED : ST_OFF;
            end
          end else if (at_start && req.second_now > HALF_MINUTE) begin
            sched_table[k].status = (sched_table[k].mask != 8'd0) ? ST_ARMED : ST_OFF;
          end
        end
        rep.entry  = 6'(k);
        rep.act    = act;
        rep.status = sched_table[k].status;
        rep.last   = (k == NUM_ENTRIES - 1);
        pending_reports.push_back(rep);
      end
    end
  endfunction

  function automatic in_item_t config_req(logic [7:0] idx, logic [1:0] st, logic son,
                                          logic [4:0] ha, logic [5:0] ma, logic eon,
                                          logic [4:0] hb, logic [5:0] mb,
                                          logic [2:0] bi, logic bv);
    in_item_t r;
    r = '0;
    r.opcode       = OP_CONFIG;
    r.entry_index  = idx;
    r.status_value = st;
    r.start_on     = son;
    r.hour_a       = ha;
    r.minute_a     = ma;
    r.end_on       = eon;
    r.hour_b       = hb;
    r.minute_b     = mb;
    r.bit_index    = bi;
    r.bit_value    = bv;
    return r;
  endfunction

  function automatic in_item_t attach_req(logic [7:0] idx, logic son, logic eon);
    in_item_t r;
    r = '0;
    r.opcode      = OP_ATTACH;
    r.entry_index = idx;
    r.start_on    = son;
    r.end_on      = eon;
    return r;
  endfunction

  function automatic in_item_t tick_req(logic [4:0] hh, logic [5:0] mm, logic [2:0] wd,
                                        logic [5:0] ss);
    in_item_t r;
    r = '0;
    r.opcode     = OP_TICK;
    r.hour_a     = hh;
    r.minute_a   = mm;
    r.bit_index  = wd;
    r.second_now = ss;
    return r;
  endfunction

  // mostly a tiny pool of times so that ticks keep hitting scheduled entries
  function automatic in_item_t random_req();
    logic [63:0] raw;
    in_item_t    r;
    int          pick;
    logic        noise;
    raw   = {$urandom, $urandom};
    r     = raw[$bits(in_item_t)-1:0];
    pick  = $urandom_range(0, 99);
    noise = ($urandom_range(0, 9) == 0);
    if (pick < 22) begin
      r.opcode = OP_CONFIG;
      if (!noise) begin
        r.entry_index  = 8'($urandom_range(0, NUM_ENTRIES - 1));
        r.status_value = ($urandom_range(0, 9) < 7) ? ST_ARMED : 2'($urandom_range(0, 3));
        r.hour_a       = 5'($urandom_range(0, 1));
        r.minute_a     = 6'($urandom_range(0, 1));
        r.hour_b       = 5'($urandom_range(0, 1));
        r.minute_b     = 6'($urandom_range(0, 1));
      end
    end else if (pick < 34) begin
      r.opcode = OP_ATTACH;
      if (!noise)
        r.entry_index = 8'($urandom_range(0, NUM_ENTRIES - 1));
    end else if (pick < 95) begin
      r.opcode = OP_TICK;
      if (!noise) begin
        r.hour_a     = 5'($urandom_range(0, 1));
        r.minute_a   = 6'($urandom_range(0, 1));
        r.second_now = 6'($urandom_range(0, 59));
      end
    end else begin
      r.opcode = OP_UNUSED;
    end
    return r;
  endfunction

  // one transfer on the request channel, then the model follows
  task automatic send_request(in_item_t req);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= req.opcode;
    in_ch.entry_index  <= req.entry_index;
    in_ch.status_value <= req.status_value;
    in_ch.start_on     <= req.start_on;
    in_ch.hour_a       <= req.hour_a;
    in_ch.minute_a     <= req.minute_a;
    in_ch.end_on       <= req.end_on;
    in_ch.hour_b       <= req.hour_b;
    in_ch.minute_b     <= req.minute_b;
    in_ch.bit_index    <= req.bit_index;
    in_ch.bit_value    <= req.bit_value;
    in_ch.second_now   <= req.second_now;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(req);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) send_request(random_req());
    wait_drained();
  endtask

  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_request(tick_req(5'd0, 6'd0, 3'd0, 6'd0));
    send_request(config_req(8'd0, ST_ARMED, 1'b1, 5'd8, 6'd15, 1'b1, 5'd8, 6'd20, 3'd2, 1'b1));
    send_request(attach_req(8'd0, 1'b1, 1'b1));
    // wrong weekday with a nonempty mask
    send_request(tick_req(5'd8, 6'd15, 3'd3, 6'd10));
    send_request(tick_req(5'd8, 6'd15, 3'd2, 6'd0));
    // second exactly at the half minute matches nothing
    send_request(tick_req(5'd8, 6'd20, 3'd2, 6'd30));
    send_request(tick_req(5'd8, 6'd20, 3'd2, 6'd59));
    // no end handler: ends in the second half of the start minute
    send_request(config_req(8'd1, ST_ARMED, 1'b1, 5'd23, 6'd59, 1'b1, 5'd0, 6'd0, 3'd0, 1'b0));
    send_request(attach_req(8'd1, 1'b1, 1'b0));
    send_request(tick_req(5'd23, 6'd59, 3'd6, 6'd29));
    send_request(tick_req(5'd23, 6'd59, 3'd6, 6'd31));
    send_request(config_req(8'd2, ST_INACTIVE, 1'b1, 5'd23, 6'd59, 1'b1, 5'd23, 6'd59,
                            3'd6, 1'b1));
    send_request(attach_req(8'd2, 1'b1, 1'b1));
    // weekday 7, actions disabled
    send_request(config_req(8'd3, ST_ARMED, 1'b0, 5'd12, 6'd0, 1'b0, 5'd12, 6'd1, 3'd7, 1'b1));
    send_request(attach_req(8'd3, 1'b1, 1'b1));
    send_request(tick_req(5'd12, 6'd0, 3'd7, 6'd0));
    send_request(tick_req(5'd12, 6'd1, 3'd7, 6'd45));
    // out of range indexes and the unused opcode are dropped
    send_request(config_req(8'd8, ST_ARMED, 1'b1, 5'd0, 6'd0, 1'b1, 5'd0, 6'd0, 3'd0, 1'b1));
    send_request(config_req(8'd255, ST_BUSY, 1'b1, 5'd31, 6'd63, 1'b1, 5'd31, 6'd63, 3'd7, 1'b1));
    send_request(attach_req(8'd200, 1'b1, 1'b1));
    send_request('1 & {OP_UNUSED, {($bits(in_item_t) - 2){1'b1}}});
    // busy written directly, times beyond their normal range
    send_request(config_req(8'd4, ST_BUSY, 1'b1, 5'd31, 6'd63, 1'b1, 5'd31, 6'd63, 3'd7, 1'b1));
    send_request(attach_req(8'd4, 1'b0, 1'b1));
    send_request(tick_req(5'd31, 6'd63, 3'd7, 6'd63));
    // cleared bit leaves the mask empty, so any weekday starts
    send_request(config_req(8'd0, ST_ARMED, 1'b1, 5'd8, 6'd15, 1'b1, 5'd8, 6'd20, 3'd2, 1'b0));
    send_request(tick_req(5'd8, 6'd15, 3'd5, 6'd0));
    wait_drained();
  endtask

  task automatic test_random_no_idle();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_random(24);
  endtask

  task automatic test_random_sender_idle();
    tx_idle_pct  = 68;
    rx_stall_pct = 0;
    run_random(24);
  endtask

  task automatic test_random_receiver_stall();
    tx_idle_pct  = 0;
    rx_stall_pct = 68;
    run_random(24);
  endtask

  task automatic test_random_both_idle();
    tx_idle_pct  = 34;
    rx_stall_pct = 34;
    run_random(24);
  endtask

  // results held back long enough that the block fills up and stops taking ticks
  task automatic test_output_backpressure();
    in_item_t req;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold      = 300;
    repeat (10) begin
      req        = random_req();
      req.opcode = OP_TICK;
      send_request(req);
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold      <= rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : check_reports
    entry_report_t got;
    entry_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{entry: out_ch.entry_out, act: out_ch.action_fired,
              status: out_ch.status_out, last: out_ch.last};
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected transfer: entry %0d act %0d status %0d last %0d",
                   got.entry, got.act, got.status, got.last);
      end else begin
        want = pending_reports.pop_front();
        if (got.entry !== want.entry || got.act !== want.act ||
            got.status !== want.status || got.last !== want.last) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("mismatch: entry %0d/%0d act %0d/%0d status %0d/%0d last %0d/%0d (exp/act)",
                     want.entry, got.entry, want.act, got.act,
                     want.status, got.status, want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL weekly_event_scheduler_core");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < NUM_ENTRIES; k++) sched_table[k] = ENTRY_RST;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_CONFIG;
    in_ch.entry_index  = '0;
    in_ch.status_value = ST_OFF;
    in_ch.start_on     = 1'b0;
    in_ch.hour_a       = '0;
    in_ch.minute_a     = '0;
    in_ch.end_on       = 1'b0;
    in_ch.hour_b       = '0;
    in_ch.minute_b     = '0;
    in_ch.bit_index    = '0;
    in_ch.bit_value    = 1'b0;
    in_ch.second_now   = '0;
    out_ch.ready       = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_backpressure();

    if (errors == 0)
      $display("PASS weekly_event_scheduler_core");
    else
      $display("FAIL weekly_event_scheduler_core");
    $finish;
  end

endmodule
